FILE: rtl/visc_pkg.sv
// Shared constants and saturating helpers for the mu(I) viscosity pipeline.
`timescale 1ns / 1ps
package visc_pkg;

  localparam int          FRAC_BITS = 32;
  localparam int          DW        = 64;
  localparam int          IDX_W     = 8;
  localparam logic [63:0] ONES      = '1;
  localparam logic [63:0] ONE_FX    = 64'd1 << FRAC_BITS;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MUS   = 8'd0;
  localparam logic [IDX_W-1:0] REG_MUD   = 8'd1;
  localparam logic [IDX_W-1:0] REG_I0    = 8'd2;
  localparam logic [IDX_W-1:0] REG_I1    = 8'd3;
  localparam logic [IDX_W-1:0] REG_DG    = 8'd4;
  localparam logic [IDX_W-1:0] REG_RHOG  = 8'd5;
  localparam logic [IDX_W-1:0] REG_NUMAX = 8'd6;
  localparam logic [IDX_W-1:0] REG_NUMIN = 8'd7;

  // {overflow, sum}, sum saturates to all ones
  function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {1'b1, ONES} : s;
  endfunction

  // {overflow, 2*a}
  function automatic logic [64:0] sat_dbl(input logic [63:0] a);
    return a[63] ? {1'b1, ONES} : {1'b0, a[62:0], 1'b0};
  endfunction

  // divisor zero, or fixed-point quotient does not fit in 64 bits
  function automatic logic div_bad(input logic [63:0] a, input logic [63:0] d);
    logic [63:0] d_hi;
    logic [63:0] a_hi;
    d_hi = d >> FRAC_BITS;
    a_hi = a >> (DW - FRAC_BITS);
    return (d == '0) || ((d_hi == '0) && (a_hi >= d));
  endfunction

endpackage

FILE: rtl/visc_div_cell.sv
// One restoring division cell: produces one quotient bit per cycle.
`timescale 1ns / 1ps
module visc_div_cell #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       in_rem,
  input  logic [63:0]       in_low,
  input  logic [63:0]       in_quo,
  input  logic [63:0]       in_div,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [63:0]       out_rem,
  output logic [63:0]       out_low,
  output logic [63:0]       out_quo,
  output logic [63:0]       out_div,
  output logic [SIDE_W-1:0] out_side
);

  logic [64:0] trial;
  logic [64:0] diff;
  logic        ge;
  logic [63:0] rem_next;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial    = {in_rem, in_low[63]};
    diff     = trial - {1'b0, in_div};
    ge       = trial >= {1'b0, in_div};
    rem_next = ge ? diff[63:0] : trial[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rem  <= rem_next;
    out_low  <= {in_low[62:0], 1'b0};
    out_quo  <= {in_quo[62:0], ge};
    out_div  <= in_div;
    out_side <= in_side;
  end

endmodule

FILE: rtl/visc_div_chain.sv
// Fixed-point divider: a row of 64 division cells with saturation on exit.
`timescale 1ns / 1ps
module visc_div_chain #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       dividend,
  input  logic [63:0]       divisor,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [63:0]       quotient,
  output logic              out_bad,
  output logic [SIDE_W-1:0] out_side
);

  localparam int DEPTH = visc_pkg::DW;

  logic              v   [0:DEPTH];
  logic [63:0]       rem [0:DEPTH];
  logic [63:0]       low [0:DEPTH];
  logic [63:0]       quo [0:DEPTH];
  logic [63:0]       dv  [0:DEPTH];
  logic [SIDE_W:0]   sd  [0:DEPTH];

  // entry: upper dividend bits preload the remainder
  assign v[0]   = in_valid;
  assign rem[0] = dividend >> (visc_pkg::DW - visc_pkg::FRAC_BITS);
  assign low[0] = dividend << visc_pkg::FRAC_BITS;
  assign quo[0] = '0;
  assign dv[0]  = divisor;
  assign sd[0]  = {visc_pkg::div_bad(dividend, divisor), in_side};

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    visc_div_cell #(.SIDE_W(SIDE_W + 1)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v[k]),
      .in_rem   (rem[k]),
      .in_low   (low[k]),
      .in_quo   (quo[k]),
      .in_div   (dv[k]),
      .in_side  (sd[k]),
      .out_valid(v[k+1]),
      .out_rem  (rem[k+1]),
      .out_low  (low[k+1]),
      .out_quo  (quo[k+1]),
      .out_div  (dv[k+1]),
      .out_side (sd[k+1])
    );
  end

  // exit: saturate on zero divisor or overflow
  assign out_valid = v[DEPTH];
  assign out_bad   = sd[DEPTH][SIDE_W];
  assign out_side  = sd[DEPTH][SIDE_W-1:0];
  assign quotient  = out_bad ? visc_pkg::ONES : quo[DEPTH];

endmodule

FILE: rtl/visc_sqrt_cell.sv
// One square root cell: produces one root bit per cycle from two radicand bits.
`timescale 1ns / 1ps
module visc_sqrt_cell #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [65:0]       in_rem,
  input  logic [63:0]       in_root,
  input  logic [127:0]      in_x,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [65:0]       out_rem,
  output logic [63:0]       out_root,
  output logic [127:0]      out_x,
  output logic [SIDE_W-1:0] out_side
);

  logic [67:0] rem2;
  logic [67:0] trial;
  logic [67:0] diff;
  logic        ge;
  logic [65:0] rem_next;

  // bring down two bits, try subtracting 4*root+1
  always_comb begin
    rem2     = {in_rem, in_x[127:126]};
    trial    = {2'b00, in_root, 2'b01};
    diff     = rem2 - trial;
    ge       = rem2 >= trial;
    rem_next = ge ? diff[65:0] : rem2[65:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rem  <= rem_next;
    out_root <= {in_root[62:0], ge};
    out_x    <= {in_x[125:0], 2'b00};
    out_side <= in_side;
  end

endmodule

FILE: rtl/visc_mul.sv
// Two-stage 64x64 fixed-point multiplier with saturation.
`timescale 1ns / 1ps
module visc_mul (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] prod,
  output logic        ovf
);

  logic [63:0]  ll;
  logic [63:0]  lh;
  logic [63:0]  hl;
  logic [63:0]  hh;
  logic [127:0] full;
  logic         hi_set;

  // partial products
  always_ff @(posedge clk) begin
    ll <= a[31:0] * b[31:0];
    lh <= a[31:0] * b[63:32];
    hl <= a[63:32] * b[31:0];
    hh <= a[63:32] * b[63:32];
  end

  always_comb begin
    full   = {64'd0, ll} + {32'd0, lh, 32'd0} + {32'd0, hl, 32'd0} + {hh, 64'd0};
    hi_set = |full[127:visc_pkg::DW + visc_pkg::FRAC_BITS];
  end

  // sum, truncate and saturate
  always_ff @(posedge clk) begin
    ovf  <= hi_set;
    prod <= hi_set ? visc_pkg::ONES : full[visc_pkg::FRAC_BITS +: visc_pkg::DW];
  end

endmodule

FILE: rtl/mu_i_rheology_viscosity_top.sv
// Top level of the regularized mu(I) viscosity pipeline.
//
// Usage:
//   Pulse start with strain_rate and pressure (unsigned/signed Q32.32); an
//   item transfers at each rising edge where start is high and busy is low.
//   busy stays low, so one cell can transfer every clock.
//   Each result shows for one cycle with done high: viscosity, friction,
//   inertial_number and saturated. Results keep input order.
//   Each item passes an input register, the three 64-cell divider rows, the
//   64-cell square-root row, five two-stage multiplier steps and an output
//   register.
//   The receiver cannot stall: every result transfers in its done cycle.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, cfg_ready
//   always high; indexes above 7 are dropped. Write only while idle.
//   Reset (rst, synchronous) clears all pipeline valids and loads register
//   defaults: I0 = 1.0, rhog = 1.0, numax all ones, others zero.
`timescale 1ns / 1ps
module mu_i_rheology_viscosity_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [63:0]                strain_rate,
  input  logic signed [63:0]         pressure,
  output logic                       done,
  output logic [63:0]                viscosity,
  output logic [63:0]                friction,
  output logic [63:0]                inertial_number,
  output logic                       saturated,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [visc_pkg::IDX_W-1:0] cfg_index,
  input  logic [63:0]                cfg_data
);

  typedef struct packed { logic [63:0] sr; logic [63:0] p; } ctx_sp_t;
  typedef struct packed { logic [63:0] sr; logic [63:0] p; logic flag; } ctx_a_t;
  typedef struct packed { logic [63:0] p; logic [63:0] s; logic flag; } ctx_b_t;
  typedef struct packed {
    logic [63:0] p; logic [63:0] nden; logic [63:0] msi0; logic flag;
  } ctx_c_t;
  typedef struct packed {
    logic [63:0] p; logic [63:0] nden; logic [63:0] msi0; logic [63:0] inum;
    logic [63:0] den; logic flag;
  } ctx_d_t;
  typedef struct packed {
    logic [63:0] p; logic [63:0] nden; logic [63:0] inum; logic [63:0] den;
    logic [63:0] sum1; logic flag;
  } ctx_e_t;
  typedef struct packed {
    logic [63:0] p; logic [63:0] nden; logic [63:0] inum; logic flag;
  } ctx_f_t;
  typedef struct packed {
    logic [63:0] nden; logic [63:0] inum; logic [63:0] mu; logic flag;
  } ctx_g_t;
  typedef struct packed { logic [63:0] inum; logic [63:0] mu; logic flag; } ctx_h_t;

  localparam int SQ_DEPTH = visc_pkg::DW;

  // configuration registers
  logic [63:0] static_friction;
  logic [63:0] dynamic_friction;
  logic [63:0] reference_inertial;
  logic [63:0] regularization_gain;
  logic [63:0] grain_diameter;
  logic [63:0] grain_density;
  logic [63:0] viscosity_ceiling;
  logic [63:0] viscosity_floor;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      static_friction     <= '0;
      dynamic_friction    <= '0;
      reference_inertial  <= visc_pkg::ONE_FX;
      regularization_gain <= '0;
      grain_diameter      <= '0;
      grain_density       <= visc_pkg::ONE_FX;
      viscosity_ceiling   <= visc_pkg::ONES;
      viscosity_floor     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        visc_pkg::REG_MUS:   static_friction     <= cfg_data;
        visc_pkg::REG_MUD:   dynamic_friction    <= cfg_data;
        visc_pkg::REG_I0:    reference_inertial  <= cfg_data;
        visc_pkg::REG_I1:    regularization_gain <= cfg_data;
        visc_pkg::REG_DG:    grain_diameter      <= cfg_data;
        visc_pkg::REG_RHOG:  grain_density       <= cfg_data;
        visc_pkg::REG_NUMAX: viscosity_ceiling   <= cfg_data;
        visc_pkg::REG_NUMIN: viscosity_floor     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: floor strain rate and pressure
  logic        v0;
  logic [63:0] sr0;
  logic [63:0] p0;
  logic [63:0] p_raw;

  assign p_raw = pressure;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    sr0 <= (strain_rate == '0) ? 64'd1 : strain_rate;
    p0  <= (p_raw[63] || (p_raw < visc_pkg::ONE_FX)) ? visc_pkg::ONE_FX : p_raw;
  end

  // q = rhog / p
  logic        vq;
  logic [63:0] q;
  logic        q_bad;
  ctx_sp_t     ctx_q_in;
  ctx_sp_t     ctx_q;

  assign ctx_q_in = '{sr: sr0, p: p0};

  visc_div_chain #(.SIDE_W($bits(ctx_sp_t))) u_div_q (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v0),
    .dividend (grain_density),
    .divisor  (p0),
    .in_side  (ctx_q_in),
    .out_valid(vq),
    .quotient (q),
    .out_bad  (q_bad),
    .out_side (ctx_q)
  );

  // s = sqrt(q): row of root cells
  logic          sq_v    [0:SQ_DEPTH];
  logic [65:0]   sq_rem  [0:SQ_DEPTH];
  logic [63:0]   sq_root [0:SQ_DEPTH];
  logic [127:0]  sq_x    [0:SQ_DEPTH];
  ctx_a_t        sq_side [0:SQ_DEPTH];

  assign sq_v[0]    = vq;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_x[0]    = {64'd0, q} << visc_pkg::FRAC_BITS;
  assign sq_side[0] = '{sr: ctx_q.sr, p: ctx_q.p, flag: q_bad};

  for (genvar k = 0; k < SQ_DEPTH; k++) begin : g_sqrt
    visc_sqrt_cell #(.SIDE_W($bits(ctx_a_t))) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sq_v[k]),
      .in_rem   (sq_rem[k]),
      .in_root  (sq_root[k]),
      .in_x     (sq_x[k]),
      .in_side  (sq_side[k]),
      .out_valid(sq_v[k+1]),
      .out_rem  (sq_rem[k+1]),
      .out_root (sq_root[k+1]),
      .out_x    (sq_x[k+1]),
      .out_side (sq_side[k+1])
    );
  end

  // step 1: dg*sr, rhog*sr, mus*I0
  logic        vb1, vb2;
  ctx_b_t      b1, b2;
  logic [63:0] t1, ndr, msi0;
  logic        ov_a, ov_b, ov_c;

  visc_mul u_mul_a (.clk(clk), .a(grain_diameter), .b(sq_side[SQ_DEPTH].sr),
                    .prod(t1), .ovf(ov_a));
  visc_mul u_mul_b (.clk(clk), .a(grain_density), .b(sq_side[SQ_DEPTH].sr),
                    .prod(ndr), .ovf(ov_b));
  visc_mul u_mul_c (.clk(clk), .a(static_friction), .b(reference_inertial),
                    .prod(msi0), .ovf(ov_c));

  always_ff @(posedge clk) begin
    if (rst) begin
      vb1 <= 1'b0;
      vb2 <= 1'b0;
    end else begin
      vb1 <= sq_v[SQ_DEPTH];
      vb2 <= vb1;
    end
    b1 <= '{p: sq_side[SQ_DEPTH].p, s: sq_root[SQ_DEPTH], flag: sq_side[SQ_DEPTH].flag};
    b2 <= b1;
  end

  logic [64:0] nd_dbl;
  ctx_c_t      c_in;

  always_comb begin
    nd_dbl = visc_pkg::sat_dbl(ndr);
    c_in   = '{p: b2.p, nden: nd_dbl[63:0], msi0: msi0,
               flag: b2.flag | ov_a | ov_b | ov_c | nd_dbl[64]};
  end

  // step 2: (dg*sr)*s
  logic        vc1, vc2;
  ctx_c_t      c1, c2;
  logic [63:0] inpre;
  logic        ov_d;

  visc_mul u_mul_d (.clk(clk), .a(t1), .b(b2.s), .prod(inpre), .ovf(ov_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      vc1 <= 1'b0;
      vc2 <= 1'b0;
    end else begin
      vc1 <= vb2;
      vc2 <= vc1;
    end
    c1 <= c_in;
    c2 <= c1;
  end

  logic [64:0] i_dbl;
  logic [64:0] den_sum;
  ctx_d_t      d_in;

  always_comb begin
    i_dbl   = visc_pkg::sat_dbl(inpre);
    den_sum = visc_pkg::sat_add(reference_inertial, i_dbl[63:0]);
    d_in    = '{p: c2.p, nden: c2.nden, msi0: c2.msi0, inum: i_dbl[63:0],
                den: den_sum[63:0], flag: c2.flag | ov_d | i_dbl[64] | den_sum[64]};
  end

  // step 3: mud*I and I*I
  logic        vd1, vd2;
  ctx_d_t      d1, d2;
  logic [63:0] p1, isq;
  logic        ov_e, ov_f;

  visc_mul u_mul_e (.clk(clk), .a(dynamic_friction), .b(i_dbl[63:0]),
                    .prod(p1), .ovf(ov_e));
  visc_mul u_mul_f (.clk(clk), .a(i_dbl[63:0]), .b(i_dbl[63:0]),
                    .prod(isq), .ovf(ov_f));

  always_ff @(posedge clk) begin
    if (rst) begin
      vd1 <= 1'b0;
      vd2 <= 1'b0;
    end else begin
      vd1 <= vc2;
      vd2 <= vd1;
    end
    d1 <= d_in;
    d2 <= d1;
  end

  logic [64:0] sum1;
  ctx_e_t      e_in;

  always_comb begin
    sum1 = visc_pkg::sat_add(d2.msi0, p1);
    e_in = '{p: d2.p, nden: d2.nden, inum: d2.inum, den: d2.den, sum1: sum1[63:0],
             flag: d2.flag | ov_e | ov_f | sum1[64]};
  end

  // step 4: I1*(I*I)
  logic        ve1, ve2;
  ctx_e_t      e1, e2;
  logic [63:0] p2;
  logic        ov_g;

  visc_mul u_mul_g (.clk(clk), .a(regularization_gain), .b(isq), .prod(p2), .ovf(ov_g));

  always_ff @(posedge clk) begin
    if (rst) begin
      ve1 <= 1'b0;
      ve2 <= 1'b0;
    end else begin
      ve1 <= vd2;
      ve2 <= ve1;
    end
    e1 <= e_in;
    e2 <= e1;
  end

  logic [64:0] num;
  ctx_f_t      f_in;

  always_comb begin
    num  = visc_pkg::sat_add(e2.sum1, p2);
    f_in = '{p: e2.p, nden: e2.nden, inum: e2.inum, flag: e2.flag | ov_g | num[64]};
  end

  // mu = num / (I0 + I)
  logic        vf;
  logic [63:0] mu;
  logic        mu_bad;
  ctx_f_t      f_out;

  visc_div_chain #(.SIDE_W($bits(ctx_f_t))) u_div_mu (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ve2),
    .dividend (num[63:0]),
    .divisor  (e2.den),
    .in_side  (f_in),
    .out_valid(vf),
    .quotient (mu),
    .out_bad  (mu_bad),
    .out_side (f_out)
  );

  // step 5: mu*p
  logic        vg1, vg2;
  ctx_g_t      g1, g2;
  logic [63:0] nnum;
  logic        ov_h;

  visc_mul u_mul_h (.clk(clk), .a(mu), .b(f_out.p), .prod(nnum), .ovf(ov_h));

  always_ff @(posedge clk) begin
    if (rst) begin
      vg1 <= 1'b0;
      vg2 <= 1'b0;
    end else begin
      vg1 <= vf;
      vg2 <= vg1;
    end
    g1 <= '{nden: f_out.nden, inum: f_out.inum, mu: mu, flag: f_out.flag | mu_bad};
    g2 <= g1;
  end

  ctx_h_t h_in;
  assign h_in = '{inum: g2.inum, mu: g2.mu, flag: g2.flag | ov_h};

  // nu = mu*p / (2*rhog*sr)
  logic        vh;
  logic [63:0] nu;
  logic        nu_bad;
  ctx_h_t      h_out;

  visc_div_chain #(.SIDE_W($bits(ctx_h_t))) u_div_nu (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vg2),
    .dividend (nnum),
    .divisor  (g2.nden),
    .in_side  (h_in),
    .out_valid(vh),
    .quotient (nu),
    .out_bad  (nu_bad),
    .out_side (h_out)
  );

  // clamp to ceiling, then floor; register the result
  logic [63:0] nu_c;
  logic [63:0] nu_f;

  always_comb begin
    nu_c = (nu > viscosity_ceiling) ? viscosity_ceiling : nu;
    nu_f = (nu_c < viscosity_floor) ? viscosity_floor : nu_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vh;
    end
    viscosity       <= nu_f;
    friction        <= h_out.mu;
    inertial_number <= h_out.inum;
    saturated       <= h_out.flag | nu_bad;
  end

  // checks
  a_no_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_floor_holds: assert property (@(posedge clk) disable iff (rst)
    done |-> viscosity >= viscosity_floor)
    else $error("viscosity below floor");

  a_ceiling_holds: assert property (@(posedge clk) disable iff (rst)
    done && (viscosity_floor <= viscosity_ceiling) |-> viscosity <= viscosity_ceiling)
    else $error("viscosity above ceiling");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the mu(I) viscosity pipeline.
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [63:0] nu;
    logic [63:0] mu;
    logic [63:0] inum;
    logic        sat;
  } cell_result_t;

  localparam int LATENCY     = 267;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic                             busy;
  logic [63:0]                      strain_rate = '0;
  logic signed [63:0]               pressure = '0;
  logic                             done;
  logic [63:0]                      viscosity;
  logic [63:0]                      friction;
  logic [63:0]                      inertial_number;
  logic                             saturated;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [visc_pkg::IDX_W-1:0]       cfg_index = '0;
  logic [63:0]                      cfg_data = '0;

  logic [63:0]  rheo_regs [8];
  cell_result_t pending_cells [$];
  bit           failed = 1'b0;
  int           cycles = 0;

  mu_i_rheology_viscosity_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("mu_i_rheology_viscosity_top test failed");
      $finish;
    end
  end

  // ---------------- predictor ----------------
  function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b,
                                        ref bit sat);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    if (p[127:96] != 0) begin
      sat = 1'b1;
      return '1;
    end
    return p[95:32];
  endfunction

  function automatic logic [63:0] q_div(input logic [63:0] a, input logic [63:0] b,
                                        ref bit sat);
    logic [127:0] q;
    if (b == 0) begin
      sat = 1'b1;
      return '1;
    end
    q = {32'b0, a, 32'b0} / {64'b0, b};
    if (q[127:64] != 0) begin
      sat = 1'b1;
      return '1;
    end
    return q[63:0];
  endfunction

  function automatic logic [63:0] q_add(input logic [63:0] a, input logic [63:0] b,
                                        ref bit sat);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) begin
      sat = 1'b1;
      return '1;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] q_dbl(input logic [63:0] a, ref bit sat);
    if (a[63]) begin
      sat = 1'b1;
      return '1;
    end
    return {a[62:0], 1'b0};
  endfunction

  function automatic logic [63:0] q_sqrt(input logic [63:0] a);
    logic [127:0] x;
    logic [63:0]  r;
    logic [63:0]  c;
    x = {32'b0, a, 32'b0};
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'b0, c} * {64'b0, c} <= x) r = c;
    end
    return r;
  endfunction

  function automatic cell_result_t viscosity_of(input logic [63:0] sr_in,
                                                input logic [63:0] p_in);
    cell_result_t res;
    bit           sat;
    logic [63:0]  sr, p, s, inum, num, den, mu, nu;
    sat = 1'b0;
    sr = (sr_in == 0) ? 64'd1 : sr_in;
    p  = (p_in[63] || p_in < visc_pkg::ONE_FX) ? visc_pkg::ONE_FX : p_in;
    s = q_sqrt(q_div(rheo_regs[visc_pkg::REG_RHOG], p, sat));
    inum = q_dbl(q_mul(q_mul(rheo_regs[visc_pkg::REG_DG], sr, sat), s, sat), sat);
    num = q_add(q_add(q_mul(rheo_regs[visc_pkg::REG_MUS], rheo_regs[visc_pkg::REG_I0], sat),
                      q_mul(rheo_regs[visc_pkg::REG_MUD], inum, sat), sat),
                q_mul(rheo_regs[visc_pkg::REG_I1], q_mul(inum, inum, sat), sat), sat);
    den = q_add(rheo_regs[visc_pkg::REG_I0], inum, sat);
    mu = q_div(num, den, sat);
    nu = q_div(q_mul(mu, p, sat),
               q_dbl(q_mul(rheo_regs[visc_pkg::REG_RHOG], sr, sat), sat), sat);
    if (nu > rheo_regs[visc_pkg::REG_NUMAX]) nu = rheo_regs[visc_pkg::REG_NUMAX];
    if (nu < rheo_regs[visc_pkg::REG_NUMIN]) nu = rheo_regs[visc_pkg::REG_NUMIN];
    res.nu = nu;
    res.mu = mu;
    res.inum = inum;
    res.sat = sat;
    return res;
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    cell_result_t want;
    if (!rst && done) begin
      if (pending_cells.size() == 0) begin
        $display("%0t: unexpected result nu=%h mu=%h I=%h sat=%b", $time,
                 viscosity, friction, inertial_number, saturated);
        failed = 1'b1;
      end else begin
        want = pending_cells.pop_front();
        if (viscosity !== want.nu) begin
          $display("%0t: viscosity exp %h got %h", $time, want.nu, viscosity);
          failed = 1'b1;
        end
        if (friction !== want.mu) begin
          $display("%0t: friction exp %h got %h", $time, want.mu, friction);
          failed = 1'b1;
        end
        if (inertial_number !== want.inum) begin
          $display("%0t: inertial_number exp %h got %h", $time, want.inum, inertial_number);
          failed = 1'b1;
        end
        if (saturated !== want.sat) begin
          $display("%0t: saturated exp %b got %b", $time, want.sat, saturated);
          failed = 1'b1;
        end
      end
    end
  end

  // ---------------- drivers ----------------
  // one cell transfer after a gap of idle cycles
  task automatic send_cell(input logic [63:0] sr, input logic [63:0] p, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    strain_rate <= sr;
    pressure    <= p;
    do @(posedge clk); while (busy);
    pending_cells.push_back(viscosity_of(sr, p));
  endtask

  task automatic write_reg(input logic [visc_pkg::IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < 8) rheo_regs[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop sending and let the pipeline empty
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly physical magnitudes, sometimes anything
  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: return rand64();
      1: return rand64() >> $urandom_range(0, 63);
      2: return visc_pkg::ONE_FX +
                ($urandom_range(0, 1) ? rand64() >> 40 : -(rand64() >> 40));
      3: return {32'b0, $urandom};
      4: return {16'b0, 16'($urandom_range(0, 65535)), $urandom};
      default: return {$urandom_range(0, 4096), $urandom};
    endcase
  endfunction

  function automatic int rand_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
  endfunction

  // ---------------- tests ----------------
  task automatic test_reset_defaults();
    send_cell(64'd0, 64'd0, 0);
    send_cell(visc_pkg::ONE_FX, 5 * visc_pkg::ONE_FX, 0);
    drain();
  endtask

  task automatic test_field_extremes();
    logic [63:0] pvals [9];
    logic [63:0] svals [3];
    pvals = '{64'h8000_0000_0000_0000, '1, 64'd0, visc_pkg::ONE_FX - 1, visc_pkg::ONE_FX,
              visc_pkg::ONE_FX + 1, 64'h7FFF_FFFF_FFFF_FFFF, 64'd3 << 31, 64'd1000 << 32};
    svals = '{64'd0, 64'd1, '1};
    write_reg(visc_pkg::REG_MUS, 64'h0000_0000_6147_AE14);
    write_reg(visc_pkg::REG_MUD, 64'h0000_0000_A3D7_0A3D);
    write_reg(visc_pkg::REG_I0,  64'h0000_0000_4779_A6B5);
    write_reg(visc_pkg::REG_I1,  64'h0000_0000_1999_9999);
    write_reg(visc_pkg::REG_DG,  64'h0000_0000_0004_1893);
    write_reg(visc_pkg::REG_RHOG, 64'd2500 << 32);
    foreach (pvals[i]) send_cell(64'd2 << 32, pvals[i], 0);
    foreach (svals[i]) send_cell(svals[i], 64'd100 << 32, i);
    send_cell('1, 64'h7FFF_FFFF_FFFF_FFFF, 0);
    drain();
  endtask

  // rhog = 0 and I0 + I = 0 give zero divisors; huge dg overflows
  task automatic test_saturation();
    write_reg(visc_pkg::REG_RHOG, 64'd0);
    write_reg(visc_pkg::REG_DG, 64'd0);
    write_reg(visc_pkg::REG_I0, 64'd0);
    send_cell(visc_pkg::ONE_FX, visc_pkg::ONE_FX, 0);
    send_cell(64'd0, 64'h8000_0000_0000_0000, 0);
    drain();
    write_reg(visc_pkg::REG_RHOG, 64'd1);
    send_cell(64'd1, visc_pkg::ONE_FX, 0);
    drain();
    write_reg(visc_pkg::REG_RHOG, '1);
    write_reg(visc_pkg::REG_DG, '1);
    write_reg(visc_pkg::REG_I0, '1);
    send_cell('1, visc_pkg::ONE_FX, 0);
    send_cell(visc_pkg::ONE_FX, 64'd7 << 32, 0);
    drain();
    // saturated value hidden by the clamps
    write_reg(visc_pkg::REG_NUMAX, 64'd12345);
    send_cell(visc_pkg::ONE_FX, visc_pkg::ONE_FX, 0);
    drain();
  endtask

  // floor above ceiling: floor wins; stray register indexes are ignored
  task automatic test_clamps();
    write_reg(visc_pkg::REG_RHOG, visc_pkg::ONE_FX);
    write_reg(visc_pkg::REG_DG, visc_pkg::ONE_FX >> 4);
    write_reg(visc_pkg::REG_I0, visc_pkg::ONE_FX >> 2);
    write_reg(visc_pkg::REG_NUMAX, visc_pkg::ONE_FX);
    write_reg(visc_pkg::REG_NUMIN, 64'd3 << 32);
    write_reg(8'd8, 64'd0);
    write_reg('1, 64'd0);
    send_cell(visc_pkg::ONE_FX, visc_pkg::ONE_FX, 0);
    send_cell(64'd1, 64'd50 << 32, 0);
    drain();
    write_reg(visc_pkg::REG_NUMIN, 64'd0);
    send_cell(64'd1, 64'd50 << 32, 0);
    send_cell('1 >> 20, 64'd50 << 32, 0);
    drain();
  endtask

  // random cells under a series of register settings
  task automatic test_random_cells(input int phases, input int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      if (ph % 4 == 0) begin
        for (int r = 0; r < 8; r++) write_reg(r[visc_pkg::IDX_W-1:0], rand64());
      end else begin
        write_reg(visc_pkg::REG_MUS, {32'b0, $urandom});
        write_reg(visc_pkg::REG_MUD, {31'b0, $urandom, 1'b0});
        write_reg(visc_pkg::REG_I0, {32'b0, $urandom} >> $urandom_range(0, 8));
        write_reg(visc_pkg::REG_I1, {30'b0, $urandom, 2'b0});
        write_reg(visc_pkg::REG_DG, {32'b0, $urandom} >> $urandom_range(4, 24));
        write_reg(visc_pkg::REG_RHOG, {$urandom_range(1, 4000), $urandom});
        write_reg(visc_pkg::REG_NUMAX, ($urandom_range(0, 1)) ? '1 : rand_value());
        write_reg(visc_pkg::REG_NUMIN,
                  ($urandom_range(0, 2) == 0) ? rand_value() : 64'd0);
      end
      for (int n = 0; n < per_phase; n++) begin
        // occasional burst with no gaps
        send_cell(rand_value(), ($urandom_range(0, 7) == 0) ? rand64() : rand_value(),
                  (n % 50 < 10) ? 0 : rand_gap());
      end
      drain();
    end
  endtask

  initial begin
    for (int r = 0; r < 8; r++) rheo_regs[r] = '0;
    rheo_regs[visc_pkg::REG_I0]    = visc_pkg::ONE_FX;
    rheo_regs[visc_pkg::REG_RHOG]  = visc_pkg::ONE_FX;
    rheo_regs[visc_pkg::REG_NUMAX] = '1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_field_extremes();
    test_saturation();
    test_clamps();
    test_random_cells(10, 200);
    if (!failed) begin
      $display("mu_i_rheology_viscosity_top test passed");
    end else begin
      $display("mu_i_rheology_viscosity_top test failed");
    end
    $finish;
  end

endmodule
